// ===== rtl/fcrs_pkg.sv =====
// Package with shared constants, feature codes and helper types for the crossing-rate statistics block.
package fcrs_pkg;

  localparam int MaxFrame = 1024;
  localparam int AddrW    = 10;
  localparam int CntW     = 11;
  localparam int SumW     = 27;

  localparam logic [2:0] FEAT_ZCR    = 3'd0;
  localparam logic [2:0] FEAT_MCR    = 3'd1;
  localparam logic [2:0] FEAT_ABSMAX = 3'd2;
  localparam logic [2:0] FEAT_MAX    = 3'd3;
  localparam logic [2:0] FEAT_MIN    = 3'd4;
  localparam logic [2:0] FEAT_MEAN   = 3'd5;

  localparam logic [2:0] CFG_ZCR    = 3'd0;
  localparam logic [2:0] CFG_MCR    = 3'd1;
  localparam logic [2:0] CFG_ABSMAX = 3'd2;
  localparam logic [2:0] CFG_MAXMIN = 3'd3;
  localparam logic [2:0] CFG_MEAN   = 3'd4;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [42:0] num;
    logic [CntW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  // Crossing test on three signed values.
  function automatic logic crosses(input logic signed [43:0] a, input logic signed [43:0] b,
                                   input logic signed [43:0] c);
    logic an, ap, bn, bp, bz, cn, cp;
    begin
      an = a < 0; ap = a > 0; bn = b < 0; bp = b > 0; bz = b == 0;
      cn = c < 0; cp = c > 0;
      crosses = (an && bp) || (ap && bn) || (bz && ((!ap && !cn) || (!an && !cp)));
    end
  endfunction

endpackage

// ===== rtl/fcrs_div.sv =====
// Shared restoring divider, one quotient bit per cycle, with floor correction for negatives.
module fcrs_div (
  input  logic             clk,
  input  logic             rst_n,
  input  fcrs_pkg::div_req_t req,
  output fcrs_pkg::div_rsp_t rsp
);
  import fcrs_pkg::*;

  logic [42:0]     q_r, q_nxt;
  logic [CntW:0]   rem_r, rem_nxt;
  logic [CntW-1:0] den_r, den_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            neg_r, neg_nxt;
  logic            done_r, done_nxt;
  logic [CntW:0]   trial;
  logic [43:0]     qs;

  // One shift-subtract step per cycle over the magnitude.
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    trial = {rem_r[CntW-1:0], q_r[42]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; den_nxt = req.den; cnt_nxt = 6'd43;
      busy_nxt = 1'b1; neg_nxt = req.neg;
    end else if (busy_r) begin
      q_nxt = {q_r[41:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt;
  end

  // Negative results round toward minus infinity.
  assign qs = neg_r ? (~{1'b0, q_r} + 44'd1 - ((rem_r != '0) ? 44'd1 : 44'd0)) : {1'b0, q_r};
  assign rsp.done = done_r;
  assign rsp.quo  = qs[31:0];

endmodule

// ===== rtl/frame_crossing_rate_stats_unit.sv =====
// Top level of the frame crossing-rate statistics block: capture, sequencer and result register.
//
// Usage: samples arrive on the in_ channel (in_valid, in_stall, in_sample, in_frame_end),
// one request per cycle while the frame is loading. The sample flagged frame_end, or the
// 1024th sample, closes the frame. The block then raises in_stall and sequences the
// results of the enabled features on the out_ channel: zero-crossing rate, mean-crossing
// rate, absolute maximum, maximum, minimum and mean, with out_last_of_run on the last one.
// Each rate or the mean goes through one shared 43-step divider. The mean-crossing rate
// reads the stored frame again, one sample per cycle from a single read port. A result
// waits in the output register while out_stall is high; the sequencer stops until it is
// taken. Configuration writes on cfg_ are taken at any time but are meant for idle
// periods. Reset (rst_n low, synchronous) empties the frame and restores the enable
// defaults; the frame memory needs no clearing.
module frame_crossing_rate_stats_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_sample,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_feature,
  output logic signed [31:0] out_value,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data
);
  import fcrs_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_PICK  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_MRD   = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;

  // Configuration registers.
  logic en_zcr_r, en_mcr_r, en_abs_r, en_mm_r, en_mean_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_zcr_r <= 1'b1; en_mcr_r <= 1'b1; en_abs_r <= 1'b1; en_mm_r <= 1'b1;
      en_mean_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ZCR:    en_zcr_r  <= cfg_data;
        CFG_MCR:    en_mcr_r  <= cfg_data;
        CFG_ABSMAX: en_abs_r  <= cfg_data;
        CFG_MAXMIN: en_mm_r   <= cfg_data;
        CFG_MEAN:   en_mean_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0]  state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic signed [15:0] max_r, max_nxt, min_r, min_nxt, p0_r, p0_nxt, p1_r, p1_nxt;
  logic [CntW-1:0] zc_r, zc_nxt, mc_r, mc_nxt;
  logic [2:0]  feat_r, feat_nxt;
  logic [5:0]  todo_r, todo_nxt;
  logic        ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [2:0]  ofeat_r, ofeat_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [CntW-1:0] ra_r, ra_nxt;
  logic [1:0]  pipe_r, pipe_nxt;
  logic signed [43:0] m0_r, m0_nxt, m1_r, m1_nxt;
  logic        accept, rd_en, rd_v_r;
  logic signed [15:0] mem [MaxFrame];
  logic signed [15:0] rd_q_r;
  logic signed [43:0] prod;
  logic [CntW-1:0] n1;
  logic signed [31:0] emit_val;
  logic [4:0] done_feat;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [15:0] amax, amin;
  logic signed [43:0] sumx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != S_LOAD;
  assign n1       = cnt_r + 11'd1;

  // Frame memory, one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (accept) mem[cnt_r[AddrW-1:0]] <= in_sample;
    if (rd_en) rd_q_r <= mem[ra_r[AddrW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r <= 1'b0;
    else rd_v_r <= rd_en;
  end
  assign rd_en = (state_r == S_MRD) && (ra_r < cnt_r);

  // N*x - sum for the sample just read; 11x16 multiply.
  assign sumx = 44'(signed'(sum_r));
  assign prod = $signed({33'd0, cnt_r}) * 44'(rd_q_r) - sumx;

  fcrs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign amax = max_r[15] ? 16'(-max_r) : max_r;
  assign amin = min_r[15] ? 16'(-min_r) : min_r;

  // Result value for the feature being emitted.
  always_comb begin
    case (feat_r)
      FEAT_ABSMAX: emit_val = (amin > amax) ? {16'd0, amin} : {16'd0, amax};
      FEAT_MAX:    emit_val = 32'(max_r);
      FEAT_MIN:    emit_val = 32'(min_r);
      default:     emit_val = drsp.quo;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; sum_nxt = sum_r; max_nxt = max_r; min_nxt = min_r;
    p0_nxt = p0_r; p1_nxt = p1_r; zc_nxt = zc_r; mc_nxt = mc_r; feat_nxt = feat_r;
    todo_nxt = todo_r; ovalid_nxt = ovalid_r; olast_nxt = olast_r; ofeat_nxt = ofeat_r;
    oval_nxt = oval_r; ra_nxt = ra_r; pipe_nxt = pipe_r; m0_nxt = m0_r; m1_nxt = m1_r;
    dreq = '0; done_feat = '0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (cnt_r >= 11'd2 && crosses(44'(p1_r), 44'(p0_r), 44'(in_sample)))
            zc_nxt = zc_r + 11'd1;
          if (cnt_r == '0 || in_sample > max_r) max_nxt = in_sample;
          if (cnt_r == '0 || in_sample < min_r) min_nxt = in_sample;
          sum_nxt = sum_r + SumW'(in_sample);
          p1_nxt = p0_r; p0_nxt = in_sample; cnt_nxt = n1;
          if (in_frame_end || n1 == 11'(MaxFrame)) begin
            state_nxt = S_PICK;
            todo_nxt = {en_mean_r, en_mm_r, en_mm_r, en_abs_r, en_mcr_r, en_zcr_r};
          end
        end
      end
      S_PICK: begin
        if (todo_r[0]) begin
          feat_nxt = FEAT_ZCR; state_nxt = S_DIV;
          dreq = '{start: 1'b1, neg: 1'b0, num: {16'd0, zc_r, 16'd0}, den: cnt_r};
        end else if (todo_r[1]) begin
          feat_nxt = FEAT_MCR; state_nxt = S_MRD; ra_nxt = '0; pipe_nxt = '0; mc_nxt = '0;
        end else if (todo_r[2]) begin
          feat_nxt = FEAT_ABSMAX; state_nxt = S_EMIT;
        end else if (todo_r[3]) begin
          feat_nxt = FEAT_MAX; state_nxt = S_EMIT;
        end else if (todo_r[4]) begin
          feat_nxt = FEAT_MIN; state_nxt = S_EMIT;
        end else if (todo_r[5]) begin
          feat_nxt = FEAT_MEAN; state_nxt = S_DIV;
          dreq.start = 1'b1;
          dreq.neg = sum_r[SumW-1];
          dreq.num = 43'({sum_r[SumW-1] ? SumW'(-sum_r) : sum_r, 16'd0});
          dreq.den = cnt_r;
        end else begin
          state_nxt = S_LOAD;
          cnt_nxt = '0; sum_nxt = '0; max_nxt = '0; min_nxt = '0; zc_nxt = '0;
          p0_nxt = '0; p1_nxt = '0;
        end
      end
      S_MRD: begin
        if (rd_en) ra_nxt = ra_r + 11'd1;
        if (rd_v_r) begin
          m1_nxt = m0_r; m0_nxt = prod;
          if (pipe_r != 2'd2) pipe_nxt = pipe_r + 2'd1;
          if (pipe_r == 2'd2 && crosses(m1_r, m0_r, prod)) mc_nxt = mc_r + 11'd1;
        end else if (!rd_en) begin
          state_nxt = S_DIV;
          dreq = '{start: 1'b1, neg: 1'b0, num: {16'd0, mc_r, 16'd0}, den: cnt_r};
        end
      end
      S_DIV: begin
        if (drsp.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1; ofeat_nxt = feat_r; oval_nxt = emit_val;
          done_feat = 5'd1 << feat_r;
          todo_nxt = todo_r & ~{done_feat[4:0] == 5'd0 ? 1'b1 : 1'b0, done_feat};
          olast_nxt = (todo_nxt == '0);
          state_nxt = S_PICK;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; sum_r <= '0; max_r <= '0; min_r <= '0;
      p0_r <= '0; p1_r <= '0; zc_r <= '0; todo_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; sum_r <= sum_nxt; max_r <= max_nxt;
      min_r <= min_nxt; p0_r <= p0_nxt; p1_r <= p1_nxt; zc_r <= zc_nxt; todo_r <= todo_nxt;
      ovalid_r <= ovalid_nxt;
    end
    mc_r <= mc_nxt; feat_r <= feat_nxt; olast_r <= olast_nxt; ofeat_r <= ofeat_nxt;
    oval_r <= oval_nxt; ra_r <= ra_nxt; pipe_r <= pipe_nxt; m0_r <= m0_nxt; m1_r <= m1_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_feature     = ofeat_r;
  assign out_value       = oval_r;
  assign out_last_of_run = olast_r;

`ifndef SYNTH
  // The input side is closed whenever the sequencer is busy with a frame.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> in_stall) else $error("input open during post-processing");
  // A stalled result is never overwritten.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_feature))
    else $error("stalled result changed");
  // The frame count never exceeds the frame memory depth.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 11'(MaxFrame)) else $error("frame count overflow");
`endif

endmodule
